>>> rtl/mpq_pkg.sv
package mpq_pkg;

  localparam int DataW    = 32;
  localparam int CountW   = 11;
  localparam int Capacity = 1024;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [CountW-1:0]       count_t;

  // heap unit operation codes
  typedef logic [1:0] heap_op_t;
  localparam heap_op_t OP_PUSH = 2'd0;
  localparam heap_op_t OP_POP  = 2'd1;
  localparam heap_op_t OP_REPL = 2'd2;

  // input action codes
  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef struct packed {
    logic     valid;
    heap_op_t op;
    data_t    val;
  } heap_cmd_t;

  typedef struct packed {
    logic  done;
    data_t ret;
    data_t top;
  } heap_sts_t;

  // true when a belongs above b in the heap
  function automatic logic ranks_above(data_t a, data_t b, logic is_max);
    ranks_above = is_max ? (a > b) : (a < b);
  endfunction

endpackage

>>> rtl/mpq_in_if.sv
interface mpq_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  mpq_pkg::data_t    value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

>>> rtl/mpq_out_if.sv
interface mpq_out_if;
  logic              valid;
  logic              ready;
  mpq_pkg::data_t    removed_value;
  logic              underflow;
  logic              dropped_full;
  mpq_pkg::data_t    median_now;
  logic              is_empty;
  mpq_pkg::count_t   held_count;

  modport source (output valid, removed_value, underflow, dropped_full, median_now,
                  is_empty, held_count, input ready);
  modport sink   (input valid, removed_value, underflow, dropped_full, median_now,
                  is_empty, held_count, output ready);
endinterface

>>> rtl/mpq_heap.sv
module mpq_heap #(
  parameter int HALF_DEPTH = (mpq_pkg::Capacity + 1) / 2,
  parameter bit IS_MAX     = 1'b1,
  localparam int AW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1,
  localparam int CW = $clog2(HALF_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mpq_pkg::heap_cmd_t  cmd,
  output mpq_pkg::heap_sts_t  sts,
  output logic [CW-1:0]       cnt
);

  localparam int XW = ((AW + 2) > (CW + 1)) ? (AW + 2) : (CW + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_POP_W  = 3'd1;
  localparam logic [2:0] S_DN_ST  = 3'd2;
  localparam logic [2:0] S_DN_L   = 3'd3;
  localparam logic [2:0] S_DN_R   = 3'd4;
  localparam logic [2:0] S_UP_ST  = 3'd5;
  localparam logic [2:0] S_UP_CMP = 3'd6;

  logic [2:0]     state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [AW-1:0]  cidx_r, cidx_nxt;
  logic           hole_r, hole_nxt;
  logic           done_r, done_nxt;
  mpq_pkg::data_t val_r, val_nxt;
  mpq_pkg::data_t cand_r, cand_nxt;
  mpq_pkg::data_t ret_r, ret_nxt;
  mpq_pkg::data_t top_r;
  mpq_pkg::data_t rdata_r;

  mpq_pkg::data_t mem [HALF_DEPTH];

  logic           rd_en, we;
  logic [AW-1:0]  rd_addr, wa;
  mpq_pkg::data_t wd;

  logic [XW-1:0]  xi, xl, xr, xc;
  logic [AW-1:0]  par;

  // child choice after the left read and after the right read
  mpq_pkg::data_t cl_val, cr_val, f_val;
  logic [AW-1:0]  cl_idx, cr_idx, f_idx;
  logic           cl_hole, cr_hole, f_hole;

  assign xi  = XW'(idx_r);
  assign xl  = (xi << 1) + XW'(1);
  assign xr  = xl + XW'(1);
  assign xc  = XW'(cnt_r);
  assign par = AW'((xi - XW'(1)) >> 1);

  always_comb begin
    if (mpq_pkg::ranks_above(rdata_r, val_r, IS_MAX)) begin
      cl_val  = rdata_r;
      cl_idx  = xl[AW-1:0];
      cl_hole = 1'b0;
    end else begin
      cl_val  = val_r;
      cl_idx  = idx_r;
      cl_hole = 1'b1;
    end
    if (mpq_pkg::ranks_above(rdata_r, cand_r, IS_MAX)) begin
      cr_val  = rdata_r;
      cr_idx  = xr[AW-1:0];
      cr_hole = 1'b0;
    end else begin
      cr_val  = cand_r;
      cr_idx  = cidx_r;
      cr_hole = hole_r;
    end
    f_val  = (state_r == S_DN_R) ? cr_val  : cl_val;
    f_idx  = (state_r == S_DN_R) ? cr_idx  : cl_idx;
    f_hole = (state_r == S_DN_R) ? cr_hole : cl_hole;
  end

  // sequence one heap operation: hole walks down or up, one level per step
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    cidx_nxt  = cidx_r;
    hole_nxt  = hole_r;
    val_nxt   = val_r;
    cand_nxt  = cand_r;
    ret_nxt   = ret_r;
    done_nxt  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    we        = 1'b0;
    wa        = idx_r;
    wd        = val_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.valid) begin
          unique case (cmd.op)
            mpq_pkg::OP_PUSH: begin
              val_nxt   = cmd.val;
              idx_nxt   = AW'(cnt_r);
              cnt_nxt   = cnt_r + CW'(1);
              state_nxt = S_UP_ST;
            end
            mpq_pkg::OP_POP: begin
              ret_nxt   = top_r;
              cnt_nxt   = cnt_r - CW'(1);
              rd_en     = 1'b1;
              rd_addr   = AW'(cnt_r - CW'(1));
              idx_nxt   = '0;
              state_nxt = S_POP_W;
            end
            mpq_pkg::OP_REPL: begin
              ret_nxt   = top_r;
              val_nxt   = cmd.val;
              idx_nxt   = '0;
              state_nxt = S_DN_ST;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_POP_W: begin
        val_nxt   = rdata_r;
        state_nxt = S_DN_ST;
      end
      S_DN_ST: begin
        if (xl >= xc) begin
          we        = 1'b1;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = xl[AW-1:0];
          state_nxt = S_DN_L;
        end
      end
      S_DN_L, S_DN_R: begin
        if (state_r == S_DN_L && xr < xc) begin
          cand_nxt  = cl_val;
          cidx_nxt  = cl_idx;
          hole_nxt  = cl_hole;
          rd_en     = 1'b1;
          rd_addr   = xr[AW-1:0];
          state_nxt = S_DN_R;
        end else if (f_hole) begin
          we        = 1'b1;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          we        = 1'b1;
          wd        = f_val;
          idx_nxt   = f_idx;
          state_nxt = S_DN_ST;
        end
      end
      S_UP_ST: begin
        if (idx_r == '0) begin
          we        = 1'b1;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = par;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (mpq_pkg::ranks_above(val_r, rdata_r, IS_MAX)) begin
          wd        = rdata_r;
          idx_nxt   = par;
          state_nxt = S_UP_ST;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  // walk payload; mirror the root entry
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    cidx_r <= cidx_nxt;
    hole_r <= hole_nxt;
    val_r  <= val_nxt;
    cand_r <= cand_nxt;
    ret_r  <= ret_nxt;
    if (we && wa == '0) begin
      top_r <= wd;
    end
  end

  // heap storage, one read and one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign sts.done = done_r;
  assign sts.ret  = ret_r;
  assign sts.top  = top_r;
  assign cnt      = cnt_r;

endmodule

>>> rtl/median_priority_queue.sv
// Median queue of up to CAPACITY signed 32-bit values, kept as a max-heap of the
// lower half and a min-heap of the upper half, each in its own single-port-read
// memory. Each beat on in_ch adds a value (action 0) or removes the lower median
// (action 1); one result beat follows on out_ch with the removed value, the new
// median, the count and the underflow/full flags. One item is in flight at a time,
// and a pending result beat holds the input off until it is taken. An add does one
// heap walk, or two when the value crosses halves (replace the top, then push it
// into the other half); a remove that rebalances does three (pop the lower top,
// pop the upper top, push it into the lower half). An underflow or a full drop
// does no heap walk. The heap memories need no clearing.
module median_priority_queue #(
  parameter int CAPACITY = mpq_pkg::Capacity
) (
  input  logic  clk,
  input  logic  rst_n,
  mpq_in_if.sink     in_ch,
  mpq_out_if.source  out_ch
);

  localparam int HALF = (CAPACITY + 1) / 2;
  localparam int CW   = $clog2(HALF + 1);
  localparam int NW   = ((CW + 1) > mpq_pkg::CountW) ? (CW + 1) : mpq_pkg::CountW;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_OP1  = 2'd1;
  localparam logic [1:0] T_OP2  = 2'd2;
  localparam logic [1:0] T_FIN  = 2'd3;

  mpq_pkg::heap_cmd_t lo_cmd, up_cmd;
  mpq_pkg::heap_sts_t lo_sts, up_sts;
  logic [CW-1:0]      lo_cnt, up_cnt;

  logic [1:0]     st_r, st_nxt;
  logic           act_r, act_nxt;
  logic           chain_r, chain_nxt;
  logic           wait_up_r, wait_up_nxt;
  logic           und_r, und_nxt;
  logic           drop_r, drop_nxt;
  mpq_pkg::data_t rem_r, rem_nxt;

  logic           out_valid_r;
  mpq_pkg::data_t out_rem_r, out_med_r;
  logic           out_und_r, out_drop_r, out_empty_r;
  mpq_pkg::count_t out_cnt_r;

  logic [NW-1:0]  n_held;
  logic           in_fire, first_done;
  mpq_pkg::data_t first_ret;

  mpq_heap #(.HALF_DEPTH(HALF), .IS_MAX(1'b1)) u_lo (
    .clk(clk), .rst_n(rst_n), .cmd(lo_cmd), .sts(lo_sts), .cnt(lo_cnt)
  );

  mpq_heap #(.HALF_DEPTH(HALF), .IS_MAX(1'b0)) u_up (
    .clk(clk), .rst_n(rst_n), .cmd(up_cmd), .sts(up_sts), .cnt(up_cnt)
  );

  assign n_held     = NW'(lo_cnt) + NW'(up_cnt);
  assign in_ch.ready = (st_r == T_IDLE) && !out_valid_r;
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign first_done = wait_up_r ? up_sts.done : lo_sts.done;
  assign first_ret  = wait_up_r ? up_sts.ret : lo_sts.ret;

  // decide heap operations for each item
  always_comb begin
    st_nxt      = st_r;
    act_nxt     = act_r;
    chain_nxt   = chain_r;
    wait_up_nxt = wait_up_r;
    und_nxt     = und_r;
    drop_nxt    = drop_r;
    rem_nxt     = rem_r;
    lo_cmd      = '0;
    up_cmd      = '0;
    unique case (st_r)
      T_IDLE: begin
        if (in_fire) begin
          act_nxt   = in_ch.action;
          und_nxt   = 1'b0;
          drop_nxt  = 1'b0;
          rem_nxt   = '0;
          chain_nxt = 1'b0;
          st_nxt    = T_OP1;
          if (in_ch.action == mpq_pkg::ACT_ADD) begin
            if (n_held >= NW'(CAPACITY)) begin
              drop_nxt = 1'b1;
              st_nxt   = T_FIN;
            end else if (lo_cnt > up_cnt) begin
              if (in_ch.value < lo_sts.top) begin
                lo_cmd      = '{valid: 1'b1, op: mpq_pkg::OP_REPL, val: in_ch.value};
                wait_up_nxt = 1'b0;
                chain_nxt   = 1'b1;
              end else begin
                up_cmd      = '{valid: 1'b1, op: mpq_pkg::OP_PUSH, val: in_ch.value};
                wait_up_nxt = 1'b1;
              end
            end else begin
              if (up_cnt != '0 && in_ch.value > up_sts.top) begin
                up_cmd      = '{valid: 1'b1, op: mpq_pkg::OP_REPL, val: in_ch.value};
                wait_up_nxt = 1'b1;
                chain_nxt   = 1'b1;
              end else begin
                lo_cmd      = '{valid: 1'b1, op: mpq_pkg::OP_PUSH, val: in_ch.value};
                wait_up_nxt = 1'b0;
              end
            end
          end else begin
            if (n_held == '0) begin
              und_nxt = 1'b1;
              st_nxt  = T_FIN;
            end else begin
              lo_cmd      = '{valid: 1'b1, op: mpq_pkg::OP_POP, val: '0};
              wait_up_nxt = 1'b0;
            end
          end
        end
      end
      T_OP1: begin
        if (first_done) begin
          if (act_r == mpq_pkg::ACT_ADD) begin
            if (chain_r) begin
              // move the displaced top across to the other half
              if (wait_up_r) begin
                lo_cmd = '{valid: 1'b1, op: mpq_pkg::OP_PUSH, val: first_ret};
              end else begin
                up_cmd = '{valid: 1'b1, op: mpq_pkg::OP_PUSH, val: first_ret};
              end
              wait_up_nxt = !wait_up_r;
              chain_nxt   = 1'b0;
              st_nxt      = T_OP2;
            end else begin
              st_nxt = T_FIN;
            end
          end else begin
            rem_nxt = lo_sts.ret;
            if (up_cnt > lo_cnt) begin
              up_cmd      = '{valid: 1'b1, op: mpq_pkg::OP_POP, val: '0};
              wait_up_nxt = 1'b1;
              chain_nxt   = 1'b1;
              st_nxt      = T_OP2;
            end else begin
              st_nxt = T_FIN;
            end
          end
        end
      end
      T_OP2: begin
        if (first_done) begin
          if (chain_r) begin
            // rebalance: upper top goes to the lower half
            lo_cmd      = '{valid: 1'b1, op: mpq_pkg::OP_PUSH, val: up_sts.ret};
            wait_up_nxt = 1'b0;
            chain_nxt   = 1'b0;
          end else begin
            st_nxt = T_FIN;
          end
        end
      end
      T_FIN: begin
        st_nxt = T_IDLE;
      end
      default: st_nxt = T_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      chain_r     <= 1'b0;
      wait_up_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      chain_r   <= chain_nxt;
      wait_up_r <= wait_up_nxt;
      if (st_r == T_FIN) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item payload and result beat
  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    und_r  <= und_nxt;
    drop_r <= drop_nxt;
    rem_r  <= rem_nxt;
    if (st_r == T_FIN) begin
      out_rem_r   <= rem_r;
      out_und_r   <= und_r;
      out_drop_r  <= drop_r;
      out_med_r   <= (lo_cnt != '0) ? lo_sts.top : '0;
      out_empty_r <= (n_held == '0);
      out_cnt_r   <= n_held[mpq_pkg::CountW-1:0];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.removed_value = out_rem_r;
  assign out_ch.underflow     = out_und_r;
  assign out_ch.dropped_full  = out_drop_r;
  assign out_ch.median_now    = out_med_r;
  assign out_ch.is_empty      = out_empty_r;
  assign out_ch.held_count    = out_cnt_r;

`ifndef SYNTH
  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input taken while a result beat is pending");

  a_halves_balanced: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == T_IDLE) |-> (lo_cnt == up_cnt || lo_cnt == up_cnt + CW'(1)))
    else $error("heap halves out of balance");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.underflow && out_ch.dropped_full))
    else $error("underflow and full drop on one beat");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.underflow) |-> (out_ch.is_empty && out_ch.removed_value == '0))
    else $error("underflow beat with data held");
`endif

endmodule

>>> tb/tb_median_priority_queue.sv
`timescale 1ns / 100ps

module tb_median_priority_queue;

  localparam int HalfDepth = (mpq_pkg::Capacity + 1) / 2;

  typedef struct {
    logic           action;
    mpq_pkg::data_t value;
  } queue_op_t;

  typedef struct {
    mpq_pkg::data_t  removed_value;
    logic            underflow;
    logic            dropped_full;
    mpq_pkg::data_t  median_now;
    logic            is_empty;
    mpq_pkg::count_t held_count;
  } queue_status_t;

  logic clk;
  logic rst_n;

  mpq_in_if  in_ch ();
  mpq_out_if out_ch ();

  median_priority_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // shadow copy of the two heaps
  mpq_pkg::data_t lo_heap [HalfDepth];
  mpq_pkg::data_t hi_heap [HalfDepth];
  int    lo_cnt;
  int    hi_cnt;

  queue_op_t     pending_ops[$];
  queue_status_t expected_status[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  recv_hold;
  int  errors;
  int  cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // heap helpers: is_max selects max-heap ordering
  function automatic bit heap_above(mpq_pkg::data_t a, mpq_pkg::data_t b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  function automatic void heap_sift(ref mpq_pkg::data_t h [HalfDepth], input int n,
                                    input bit is_max);
    int i;
    int l;
    int r;
    int b;
    mpq_pkg::data_t t;
    i = 0;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      b = i;
      if (l < n && heap_above(h[l], h[b], is_max)) b = l;
      if (r < n && heap_above(h[r], h[b], is_max)) b = r;
      if (b == i) return;
      t = h[i]; h[i] = h[b]; h[b] = t;
      i = b;
    end
  endfunction

  function automatic void heap_insert(ref mpq_pkg::data_t h [HalfDepth], ref int n,
                                      input mpq_pkg::data_t v, input bit is_max);
    int i;
    int p;
    mpq_pkg::data_t t;
    i = n;
    h[i] = v;
    n = n + 1;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!heap_above(h[i], h[p], is_max)) break;
      t = h[i]; h[i] = h[p]; h[p] = t;
      i = p;
    end
  endfunction

  function automatic mpq_pkg::data_t heap_take(ref mpq_pkg::data_t h [HalfDepth], ref int n,
                                               input bit is_max);
    mpq_pkg::data_t top;
    top = h[0];
    n = n - 1;
    h[0] = h[n];
    heap_sift(h, n, is_max);
    return top;
  endfunction

  function automatic mpq_pkg::data_t heap_swap_top(ref mpq_pkg::data_t h [HalfDepth],
                                                   input int n, input mpq_pkg::data_t v,
                                                   input bit is_max);
    mpq_pkg::data_t top;
    top = h[0];
    h[0] = v;
    heap_sift(h, n, is_max);
    return top;
  endfunction

  // predict the status beat for one accepted operation
  function automatic queue_status_t predict_median(queue_op_t op);
    queue_status_t s;
    mpq_pkg::data_t moved;
    int n;
    s = '{default: '0};
    n = lo_cnt + hi_cnt;
    if (op.action == mpq_pkg::ACT_ADD) begin
      if (n >= mpq_pkg::Capacity) begin
        s.dropped_full = 1'b1;
      end else if (lo_cnt > hi_cnt) begin
        if (op.value < lo_heap[0]) begin
          moved = heap_swap_top(lo_heap, lo_cnt, op.value, 1'b1);
          heap_insert(hi_heap, hi_cnt, moved, 1'b0);
        end else begin
          heap_insert(hi_heap, hi_cnt, op.value, 1'b0);
        end
      end else begin
        if (hi_cnt > 0 && op.value > hi_heap[0]) begin
          moved = heap_swap_top(hi_heap, hi_cnt, op.value, 1'b0);
          heap_insert(lo_heap, lo_cnt, moved, 1'b1);
        end else begin
          heap_insert(lo_heap, lo_cnt, op.value, 1'b1);
        end
      end
    end else begin
      if (n == 0) begin
        s.underflow = 1'b1;
      end else begin
        s.removed_value = heap_take(lo_heap, lo_cnt, 1'b1);
        if (hi_cnt > lo_cnt) begin
          moved = heap_take(hi_heap, hi_cnt, 1'b0);
          heap_insert(lo_heap, lo_cnt, moved, 1'b1);
        end
      end
    end
    n = lo_cnt + hi_cnt;
    s.median_now = (lo_cnt > 0) ? lo_heap[0] : '0;
    s.is_empty   = (n == 0);
    s.held_count = mpq_pkg::count_t'(n);
    return s;
  endfunction

  task automatic push_op(logic act, mpq_pkg::data_t v);
    queue_op_t op;
    op.action = act;
    op.value  = v;
    pending_ops.push_back(op);
  endtask

  function automatic mpq_pkg::data_t rand_value();
    case ($urandom_range(0, 5))
      0:       return mpq_pkg::data_t'($urandom_range(0, 15)) - 8;
      1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2:       return mpq_pkg::data_t'($urandom_range(0, 200)) - 100;
      default: return mpq_pkg::data_t'($urandom);
    endcase
  endfunction

  // driver: present queued operations, advance on each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.action <= mpq_pkg::ACT_ADD;
      in_ch.value  <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_status.push_back(predict_median('{in_ch.action, in_ch.value}));
      if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        queue_op_t op;
        op = pending_ops.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.action <= op.action;
        in_ch.value  <= op.value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stall control, with an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold    <= recv_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: check each result beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected result beat, median %0d", $time, out_ch.median_now);
        errors++;
      end else begin
        queue_status_t e;
        e = expected_status.pop_front();
        if (out_ch.removed_value !== e.removed_value) begin
          $display("%0t: removed_value exp %0d got %0d", $time, e.removed_value,
                   out_ch.removed_value);
          errors++;
        end
        if (out_ch.underflow !== e.underflow) begin
          $display("%0t: underflow exp %0b got %0b", $time, e.underflow, out_ch.underflow);
          errors++;
        end
        if (out_ch.dropped_full !== e.dropped_full) begin
          $display("%0t: dropped_full exp %0b got %0b", $time, e.dropped_full,
                   out_ch.dropped_full);
          errors++;
        end
        if (out_ch.median_now !== e.median_now) begin
          $display("%0t: median_now exp %0d got %0d", $time, e.median_now, out_ch.median_now);
          errors++;
        end
        if (out_ch.is_empty !== e.is_empty) begin
          $display("%0t: is_empty exp %0b got %0b", $time, e.is_empty, out_ch.is_empty);
          errors++;
        end
        if (out_ch.held_count !== e.held_count) begin
          $display("%0t: held_count exp %0d got %0d", $time, e.held_count, out_ch.held_count);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_ch.valid || expected_status.size() > 0)
      @(posedge clk);
  endtask

  // random phase: add_pct sets the mix of adds and removes
  task automatic random_phase(int count, int add_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < add_pct) push_op(mpq_pkg::ACT_ADD, rand_value());
      else push_op(mpq_pkg::ACT_REMOVE, mpq_pkg::data_t'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    errors = 0;
    cycles = 0;
    recv_hold = 0;
    send_idle_pct = 18;
    recv_idle_pct = 50;
    lo_cnt = 0;
    hi_cnt = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: underflow, extremes, equal values, crossing halves
    push_op(mpq_pkg::ACT_REMOVE, 32'sh7fffffff);
    push_op(mpq_pkg::ACT_ADD, 32'sh80000000);
    push_op(mpq_pkg::ACT_ADD, 32'sh7fffffff);
    push_op(mpq_pkg::ACT_ADD, 0);
    push_op(mpq_pkg::ACT_ADD, -1);
    push_op(mpq_pkg::ACT_ADD, 5);
    push_op(mpq_pkg::ACT_ADD, 5);
    push_op(mpq_pkg::ACT_ADD, 5);
    push_op(mpq_pkg::ACT_ADD, -100);
    push_op(mpq_pkg::ACT_ADD, 100);
    repeat (10) push_op(mpq_pkg::ACT_REMOVE, 0);
    push_op(mpq_pkg::ACT_ADD, 1);
    push_op(mpq_pkg::ACT_REMOVE, 0);
    wait_drained();

    // sender pauses until the queue is drained, then builds up a fill level
    random_phase(120, 90);
    wait_drained();

    // hold the receiver off at first, fill to capacity, then overfill
    send_idle_pct = 50;
    recv_idle_pct = 18;
    recv_hold = 300;
    repeat (mpq_pkg::Capacity - (lo_cnt + hi_cnt) + 6) push_op(mpq_pkg::ACT_ADD, rand_value());
    push_op(mpq_pkg::ACT_REMOVE, 0);
    push_op(mpq_pkg::ACT_ADD, 32'sh7fffffff);
    push_op(mpq_pkg::ACT_ADD, 32'sh80000000);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(40, 30);
    wait_drained();

    repeat (200) @(posedge clk);
    if (errors == 0 && expected_status.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mpq_pkg.sv
rtl/mpq_in_if.sv
rtl/mpq_out_if.sv
rtl/mpq_heap.sv
rtl/median_priority_queue.sv
tb/tb_median_priority_queue.sv
